// File: sv/bwcmg_pkg.sv
// Shared widths, register indexes and reset values for the gray mixing core.
package bwcmg_pkg;

   localparam int PixelWidth = 8;
   localparam int RatioWidth = 11;
   localparam int RatioCount = 6;
   localparam int IndexWidth = $clog2(RatioCount);
   localparam int ProdWidth  = PixelWidth + 1 + RatioWidth;
   localparam int SumWidth   = ProdWidth + 1;

   typedef logic [PixelWidth-1:0]        pixel_type;
   typedef logic signed [RatioWidth-1:0] ratio_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;

   typedef enum logic [IndexWidth-1:0] {
      RATIO_ZERO  = 3'd0,
      RATIO_ONE   = 3'd1,
      RATIO_TWO   = 3'd2,
      RATIO_THREE = 3'd3,
      RATIO_FOUR  = 3'd4,
      RATIO_FIVE  = 3'd5
   } ratio_index_type;

   localparam ratio_type RatioReset [RatioCount] = '{
      11'sd102, 11'sd154, 11'sd102, 11'sd154, 11'sd51, 11'sd205
   };

endpackage

// File: sv/black_white_channel_mix_gray_core.sv
// Three-stage pipelined black-and-white gray mixer with programmable channel ratios.
//
// Each input word is one blue, green and red pixel; each output word is one
// 8-bit gray level. The channels are sorted into min, mid and max, the max and
// min channels each pick a signed ratio in 1/256 units, and the result is
// (max-mid)*ratio_a + (mid-min)*ratio_b + min, rounded to nearest and clamped
// to 0..255. The pipeline accepts one word per clock when not stalled; its
// stages are sorting and ratio selection, the two multiplies, then the final
// add and clamp into the output register. Ratios are to be written through the
// csr port only while the pipeline is empty; the block does not enforce this.
module black_white_channel_mix_gray_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bwcmg_pkg::pixel_type               req_blue,
   input  bwcmg_pkg::pixel_type               req_green,
   input  bwcmg_pkg::pixel_type               req_red,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bwcmg_pkg::pixel_type               rsp_gray,
   input  logic                               csr_write,
   input  logic [bwcmg_pkg::IndexWidth-1:0]   csr_index,
   input  bwcmg_pkg::ratio_type               csr_data
);
   import bwcmg_pkg::*;

   ratio_type ratio_ff [RatioCount];

   logic      s1_valid_ff;
   pixel_type s1_diff_a_ff, s1_diff_a_in;
   pixel_type s1_diff_b_ff, s1_diff_b_in;
   pixel_type s1_low_ff, s1_low_in;
   ratio_type s1_ratio_a_ff, s1_ratio_a_in;
   ratio_type s1_ratio_b_ff, s1_ratio_b_in;

   logic      s2_valid_ff;
   prod_type  s2_prod_a_ff, s2_prod_a_in;
   prod_type  s2_prod_b_ff, s2_prod_b_in;
   pixel_type s2_low_ff;

   logic      rsp_valid_ff;
   pixel_type rsp_gray_ff, rsp_gray_in;

   logic      out_move;
   logic      s2_move;
   logic      s1_move;
   pixel_type low, high, middle;
   sum_type   sum;

   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = !s2_valid_ff || out_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_gray  = rsp_gray_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RatioCount; i++) begin
            ratio_ff[i] <= RatioReset[i];
         end
      end else if (csr_write) begin
         case (csr_index)
            RATIO_ZERO, RATIO_ONE, RATIO_TWO, RATIO_THREE, RATIO_FOUR, RATIO_FIVE: begin
               ratio_ff[csr_index] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Stage one: sort the channels and pick the two ratios.
   always_comb begin
      pixel_type bg_low, bg_high;
      bg_low  = (req_blue < req_green) ? req_blue : req_green;
      bg_high = (req_blue > req_green) ? req_blue : req_green;
      low     = (bg_low < req_red) ? bg_low : req_red;
      high    = (bg_high > req_red) ? bg_high : req_red;
      middle  = PixelWidth'((PixelWidth+2)'(req_blue) + (PixelWidth+2)'(req_green)
                + (PixelWidth+2)'(req_red) - (PixelWidth+2)'(low)
                - (PixelWidth+2)'(high));
      s1_diff_a_in = high - middle;
      s1_diff_b_in = middle - low;
      s1_low_in    = low;
      if (low == req_red) begin
         s1_ratio_b_in = ratio_ff[RATIO_FOUR];
      end else if (low == req_green) begin
         s1_ratio_b_in = ratio_ff[RATIO_ONE];
      end else begin
         s1_ratio_b_in = ratio_ff[RATIO_TWO];
      end
      if (high == req_red) begin
         s1_ratio_a_in = ratio_ff[RATIO_ONE];
      end else if (high == req_green) begin
         s1_ratio_a_in = ratio_ff[RATIO_THREE];
      end else begin
         s1_ratio_a_in = ratio_ff[RATIO_FIVE];
      end
   end

   // Stage two: the two signed multiplies.
   assign s2_prod_a_in = ProdWidth'($signed({1'b0, s1_diff_a_ff})) * ProdWidth'(s1_ratio_a_ff);
   assign s2_prod_b_in = ProdWidth'($signed({1'b0, s1_diff_b_ff})) * ProdWidth'(s1_ratio_b_ff);

   // Stage three: add, round and clamp.
   always_comb begin
      sum = SumWidth'(s2_prod_a_ff) + SumWidth'(s2_prod_b_ff)
            + $signed({{(SumWidth-2*PixelWidth){1'b0}}, s2_low_ff, 8'h80});
      if (sum[SumWidth-1]) begin
         rsp_gray_in = '0;
      end else if (|sum[SumWidth-2:2*PixelWidth]) begin
         rsp_gray_in = '1;
      end else begin
         rsp_gray_in = sum[2*PixelWidth-1:PixelWidth];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_move) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s1_diff_a_ff  <= s1_diff_a_in;
         s1_diff_b_ff  <= s1_diff_b_in;
         s1_low_ff     <= s1_low_in;
         s1_ratio_a_ff <= s1_ratio_a_in;
         s1_ratio_b_ff <= s1_ratio_b_in;
      end
      if (s2_move) begin
         s2_prod_a_ff <= s2_prod_a_in;
         s2_prod_b_ff <= s2_prod_b_in;
         s2_low_ff    <= s1_low_ff;
      end
      if (out_move) begin
         rsp_gray_ff <= rsp_gray_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && s1_valid_ff && s2_valid_ff))
      else $error("input stalled while the pipeline has room");

   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_move) |=> ($stable(s2_prod_a_ff) && $stable(s2_prod_b_ff)
                                      && s2_valid_ff))
      else $error("held product stage changed");

   assert property (@(posedge clock)
      $past(reset) |-> (ratio_ff[RATIO_ONE] == RatioReset[RATIO_ONE]
                        && ratio_ff[RATIO_FIVE] == RatioReset[RATIO_FIVE]))
      else $error("ratio registers not at reset value after reset");

   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_move) |=> s2_valid_ff)
      else $error("word lost between first and second stage");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the gray mixing core with random handshakes and ratio settings.
module tb;
   import bwcmg_pkg::*;

   localparam int PipeDepth    = 3;
   localparam int CycleLimit   = 400000;
   localparam int RandomPixels = 1850;
   localparam logic [IndexWidth-1:0] SpareIndexLow  = IndexWidth'(RatioCount);
   localparam logic [IndexWidth-1:0] SpareIndexHigh = '1;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pixel_type             req_blue  = '0;
   pixel_type             req_green = '0;
   pixel_type             req_red   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pixel_type             rsp_gray;
   logic                  csr_write = 1'b0;
   logic [IndexWidth-1:0] csr_index = '0;
   ratio_type             csr_data  = '0;

   int          ratio_shadow [RatioCount] = '{102, 154, 102, 154, 51, 205};
   pixel_type   gray_expected [$];
   int          error_count   = 0;
   int          cycle_count   = 0;
   int          burst_left    = 0;
   int          gap_max       = 6;
   logic [15:0] stall_pattern = '0;
   logic [5:0]  stall_tick    = '0;

   black_white_channel_mix_gray_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_gray  (rsp_gray),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver stalls on a rotating pattern that is redrawn whenever the six-bit tick counter wraps.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      if (stall_tick == '0) begin
         case ($urandom_range(3))
            0: stall_pattern <= '0;
            1: stall_pattern <= 16'($urandom & $urandom & $urandom);
            default: stall_pattern <= 16'($urandom);
         endcase
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
      end
      rsp_stall <= stall_pattern[15];
   end

   always @(posedge clock) begin : gray_check
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gray_expected.size() == 0) begin
            $error("gray: no word expected, actual %0d", rsp_gray);
            error_count++;
         end else begin
            want = gray_expected.pop_front();
            if (rsp_gray !== want) begin
               $error("gray: expected %0d, actual %0d", want, rsp_gray);
               error_count++;
            end
         end
      end
   end

   function automatic pixel_type expected_gray(input pixel_type blue, green, red);
      int b, g, r, lo, hi, mid, ra, rb, total;
      b = blue;
      g = green;
      r = red;
      lo = (b < g) ? b : g;
      lo = (lo < r) ? lo : r;
      hi = (b > g) ? b : g;
      hi = (hi > r) ? hi : r;
      mid = b + g + r - lo - hi;
      if (lo == r) rb = ratio_shadow[RATIO_FOUR];
      else if (lo == g) rb = ratio_shadow[RATIO_ONE];
      else rb = ratio_shadow[RATIO_TWO];
      if (hi == r) ra = ratio_shadow[RATIO_ONE];
      else if (hi == g) ra = ratio_shadow[RATIO_THREE];
      else ra = ratio_shadow[RATIO_FIVE];
      total = (hi - mid) * ra + (mid - lo) * rb + lo * 256 + 128;
      if (total < 0) return '0;
      if ((total >>> 8) > 255) return '1;
      return pixel_type'(total >>> 8);
   endfunction

   function automatic int pick_ratio(input int mode);
      case (mode)
         0: return int'($urandom_range(1280)) - 512;
         1: return int'(ratio_type'($urandom));
         2: begin
            case ($urandom_range(5))
               0: return -1024;
               1: return -512;
               2: return 0;
               3: return 256;
               4: return 768;
               default: return 1023;
            endcase
         end
         3: return int'($urandom_range(256));
         default: return int'($urandom_range(64)) - 32;
      endcase
   endfunction

   task automatic send_pixel(input pixel_type blue, green, red);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(gap_max);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_blue  <= blue;
      req_green <= green;
      req_red   <= red;
      gray_expected.push_back(expected_gray(blue, green, red));
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   task automatic settle_pipeline;
      req_valid <= 1'b0;
      burst_left = 0;
      while (gray_expected.size() != 0) @(posedge clock);
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IndexWidth-1:0] index, input ratio_type value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      if (index < RatioCount) ratio_shadow[index] = value;
   endtask

   task automatic load_ratios(input int values [RatioCount]);
      foreach (values[i]) write_csr(IndexWidth'(i), ratio_type'(values[i]));
   endtask

   task automatic test_reset_ratios;
      logic [23:0] corner_pixels [20] = '{
         24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
         24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h0A0AC8, 24'hC8C80A,
         24'h0AC80A, 24'hC80AC8, 24'hC80A0A, 24'h0AC8C8, 24'h1E3C5A,
         24'h5A3C1E, 24'h3C1E5A, 24'h3C5A1E, 24'h1E5A3C, 24'h5A1E3C
      };
      foreach (corner_pixels[i])
         send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
      settle_pipeline();
   endtask

   task automatic test_ratio_extremes;
      // A ratio of one half on a step of one lands exactly on the rounding midpoint.
      load_ratios('{128, 128, 128, 128, 128, 128});
      send_pixel(8'd0, 8'd0, 8'd1);
      settle_pipeline();
      write_csr(RATIO_ONE, 11'sd127);
      send_pixel(8'd0, 8'd0, 8'd1);
      settle_pipeline();
      load_ratios('{-1024, -1024, -1024, -1024, -1024, -1024});
      send_pixel(8'd0, 8'd128, 8'd255);
      send_pixel(8'd255, 8'd128, 8'd0);
      settle_pipeline();
      load_ratios('{1023, 1023, 1023, 1023, 1023, 1023});
      send_pixel(8'd0, 8'd128, 8'd255);
      send_pixel(8'd255, 8'd128, 8'd0);
      settle_pipeline();
      load_ratios('{-512, 768, -512, 768, -512, 768});
      send_pixel(8'd40, 8'd200, 8'd120);
      settle_pipeline();
      // Writes beyond the last ratio must leave the table untouched.
      write_csr(SpareIndexLow, 11'sd0);
      write_csr(SpareIndexHigh, -11'sd1);
      send_pixel(8'd40, 8'd200, 8'd120);
      settle_pipeline();
   endtask

   task automatic test_random_mix;
      int sent;
      int phase_len;
      int mode;
      int values [RatioCount];
      pixel_type b, g, r;
      sent = 0;
      while (sent < RandomPixels) begin
         mode = $urandom_range(4);
         foreach (values[i]) values[i] = pick_ratio(mode);
         load_ratios(values);
         if ($urandom_range(2) == 0)
            write_csr(IndexWidth'($urandom_range(SpareIndexLow, SpareIndexHigh)),
                      ratio_type'($urandom));
         gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
         phase_len = $urandom_range(40, 200);
         if (phase_len > RandomPixels - sent) phase_len = RandomPixels - sent;
         repeat (phase_len) begin
            b = pixel_type'($urandom);
            g = pixel_type'($urandom);
            r = pixel_type'($urandom);
            case ($urandom_range(9))
               0: g = b;
               1: r = g;
               2: r = b;
               3: begin
                  g = b;
                  r = b;
               end
               4: begin
                  b = '0;
                  r = '1;
               end
               default: ;
            endcase
            send_pixel(b, g, r);
            sent++;
         end
         settle_pipeline();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_ratios();
      test_ratio_extremes();
      test_random_mix();
      if (error_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: black_white_channel_mix_gray_core.f
sv/bwcmg_pkg.sv
sv/black_white_channel_mix_gray_core.sv
tb/sv/tb.sv
